FILE: sv/ctp_pkg.sv
// Shared constants, item types and the arctangent table of the CORDIC core.
`default_nettype none
package ctp_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int GUARD_BITS    = 8;
  localparam int ANGLE_W       = 16;
  localparam int Z_W           = 32;
  localparam int ITER          = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int XY_W          = COORD_WIDTH + GUARD_BITS + 3;
  localparam int UX_W          = XY_W - 1;
  localparam int GAIN_W        = 32;
  localparam int PROD_W        = UX_W + GAIN_W;
  localparam int LATENCY       = ITER + 3;

  localparam logic [GAIN_W-1:0] INV_GAIN = 32'h9B74EDA8;
  localparam logic [Z_W-1:0]    Z_PI     = 32'h80000000;
  localparam logic [Z_W-1:0]    Z_HALF   = 32'h00008000;

  localparam logic [Z_W-1:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0]    magnitude;
    logic signed [ANGLE_W-1:0] angle;
  } out_item_t;

  typedef struct packed {
    logic                   valid;
    logic                   origin;
    logic signed [XY_W-1:0] x;
    logic [Z_W-1:0]         z;
  } ctp_vec_t;

endpackage
`default_nettype wire

FILE: sv/ctp_cordic.sv
// Pre-rotation into the right half-plane followed by one register stage per CORDIC iteration.
`default_nettype none
module ctp_cordic
  import ctp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output ctp_vec_t      vec_out
);

  logic signed [XY_W-1:0] x_r   [0:ITER];
  logic signed [XY_W-1:0] y_r   [0:ITER];
  logic [Z_W-1:0]         z_r   [0:ITER];
  logic                   org_r [0:ITER];
  logic                   vld_r [0:ITER];

  logic signed [XY_W-1:0] ext_x, ext_y;
  logic signed [XY_W-1:0] x0_nxt, y0_nxt;
  logic [Z_W-1:0]         z0_nxt;

  assign ext_x = {{(XY_W-COORD_WIDTH-GUARD_BITS){in_item.coord_x[COORD_WIDTH-1]}},
                  in_item.coord_x, {GUARD_BITS{1'b0}}};
  assign ext_y = {{(XY_W-COORD_WIDTH-GUARD_BITS){in_item.coord_y[COORD_WIDTH-1]}},
                  in_item.coord_y, {GUARD_BITS{1'b0}}};

  always_comb begin
    if (in_item.coord_x[COORD_WIDTH-1]) begin
      x0_nxt = -ext_x;
      y0_nxt = -ext_y;
      z0_nxt = Z_PI;
    end else begin
      x0_nxt = ext_x;
      y0_nxt = ext_y;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    x_r[0]   <= x0_nxt;
    y_r[0]   <= y0_nxt;
    z_r[0]   <= z0_nxt;
    org_r[0] <= (in_item.coord_x == '0) && (in_item.coord_y == '0);
  end

  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [XY_W-1:0] xs, ys, x_nxt, y_nxt;
    logic [Z_W-1:0]         z_nxt;

    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_comb begin
      if (!y_r[i][XY_W-1]) begin
        x_nxt = x_r[i] + ys;
        y_nxt = y_r[i] - xs;
        z_nxt = z_r[i] + ATAN_TAB[i];
      end else begin
        x_nxt = x_r[i] - ys;
        y_nxt = y_r[i] + xs;
        z_nxt = z_r[i] - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      x_r[i+1]   <= x_nxt;
      y_r[i+1]   <= y_nxt;
      z_r[i+1]   <= z_nxt;
      org_r[i+1] <= org_r[i];
    end
  end

  assign vec_out.valid  = vld_r[ITER];
  assign vec_out.origin = org_r[ITER];
  assign vec_out.x      = x_r[ITER];
  assign vec_out.z      = z_r[ITER];

endmodule
`default_nettype wire

FILE: sv/ctp_gain.sv
// Gain correction by multiplication, rounding, saturation and angle rounding; the origin gives zeros.
`default_nettype none
module ctp_gain
  import ctp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire ctp_vec_t vec_in,
  output logic          out_valid,
  output out_item_t     out_item
);

  localparam int MAGF_W = UX_W + 1 - GUARD_BITS;

  logic [UX_W-1:0]    ux;
  logic [PROD_W-1:0]  prod_nxt, prod_r;
  logic [ANGLE_W-1:0] ang_nxt, ang_r;
  logic [Z_W-1:0]     z_rnd;
  logic               org_r, vld_r;

  logic [UX_W-1:0]        t;
  logic [UX_W:0]          rnd;
  logic [MAGF_W-1:0]      mag_full;
  logic [COORD_WIDTH-1:0] mag;
  out_item_t              item_nxt, item_r;
  logic                   out_vld_r;

  assign ux       = vec_in.x[XY_W-1] ? '0 : vec_in.x[UX_W-1:0];
  assign prod_nxt = PROD_W'(ux) * PROD_W'(INV_GAIN);
  assign z_rnd    = vec_in.z + Z_HALF;
  assign ang_nxt  = z_rnd[Z_W-1 -: ANGLE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vec_in.valid;
    end
    prod_r <= prod_nxt;
    ang_r  <= ang_nxt;
    org_r  <= vec_in.origin;
  end

  assign t        = prod_r[PROD_W-1:GAIN_W];
  assign rnd      = {1'b0, t} + (UX_W+1)'(1 << (GUARD_BITS-1));
  assign mag_full = rnd[UX_W:GUARD_BITS];

  always_comb begin
    if (|mag_full[MAGF_W-1:COORD_WIDTH]) begin
      mag = '1;
    end else begin
      mag = mag_full[COORD_WIDTH-1:0];
    end
    if (org_r) begin
      item_nxt.magnitude = '0;
      item_nxt.angle     = '0;
    end else begin
      item_nxt.magnitude = mag;
      item_nxt.angle     = ang_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r;
    end
    item_r <= item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

FILE: sv/cartesian_to_polar_core.sv
// Top level of the pipelined CORDIC cartesian to polar converter.
//
// One item is a point (coord_x, coord_y), two signed 16-bit values, given on
// in_item and taken at a rising edge where start is high and busy is low.
// Busy is always low, so a new item may be started in every cycle.
// Each item gives one result on out_item: the rounded magnitude and the angle
// as a signed binary angle where 32768 units equal pi. The result is shown for
// exactly one cycle, marked by out_valid, and cannot be held off.
// From the accepting edge, an item passes through one pre-rotation register,
// one register per CORDIC iteration, the gain multiplier register and the
// output register that drives out_valid. Throughput is one item per cycle.
// A synchronous reset clears the valid bits of every stage, so items in flight
// are dropped and no result appears until a new item has passed through.
`default_nettype none
module cartesian_to_polar_core
  import ctp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  ctp_vec_t vec;

  assign busy = 1'b0;

  ctp_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_item  (in_item),
    .vec_out  (vec)
  );

  ctp_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .vec_in    (vec),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: sv/ctp_checker.sv
// Port-level checks of the converter's timing and origin handling, bound to the top level.
`default_nettype none
module ctp_checker
  import ctp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire out_item_t out_item
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy == 1'b0)
    else $error("busy raised although the pipeline never stalls");

  a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LATENCY out_valid)
    else $error("accepted item gave no result at the expected latency");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result appeared without an accepted item");

  a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.coord_x == '0 && in_item.coord_y == '0
    |-> ##LATENCY out_valid && out_item.magnitude == '0 && out_item.angle == '0)
    else $error("origin did not give zero magnitude and angle");

endmodule

bind cartesian_to_polar_core ctp_checker u_ctp_checker (.*);
`default_nettype wire
